// ===== rtl/core/hlps_pkg.sv =====
// Shared types and constants for the half-duplex poll link sequencer.
`timescale 1ns / 1ps

package hlps_pkg;

  localparam int unsigned TimeW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0] TimeMax = '1;

  // Link phases, in the encoding the phase field carries
  typedef enum logic [2:0] {
    PH_PRESEND = 3'd0,
    PH_WAIT    = 3'd1,
    PH_SEND    = 3'd2,
    PH_RECV    = 3'd3,
    PH_DONE    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    CAUSE_GAP   = 2'd0,
    CAUSE_NOANS = 2'd1,
    CAUSE_FULL  = 2'd2
  } cause_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SEND_INTERVAL   = 2'd0,
    REG_TURNAROUND_WAIT = 2'd1,
    REG_BYTE_GAP_LIMIT  = 2'd2,
    REG_NO_ANSWER_LIMIT = 2'd3
  } reg_idx_e;

  localparam logic [TimeW-1:0] SendIntervalRst   = 16'd15000;
  localparam logic [TimeW-1:0] TurnaroundWaitRst = 16'd15;
  localparam logic [TimeW-1:0] ByteGapLimitRst   = 16'd15;
  localparam logic [TimeW-1:0] NoAnswerLimitRst  = 16'd2000;

  typedef struct packed {
    logic [TimeW-1:0] send_interval;
    logic [TimeW-1:0] turnaround_wait;
    logic [TimeW-1:0] byte_gap_limit;
    logic [TimeW-1:0] no_answer_limit;
  } cfg_t;

  typedef struct packed {
    phase_e           phase;
    logic [TimeW-1:0] phase_timer;
    logic [TimeW-1:0] idle_timer;
    logic [ByteW-1:0] rx_count;
  } link_state_t;

  typedef struct packed {
    logic [TimeW-1:0] elapsed;
    logic             send_request;
    logic             tx_busy;
    logic             rx_valid;
    logic [ByteW-1:0] rx_byte;
  } hlps_in_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic             begin_transmit;
    logic             start_send;
    logic             store_valid;
    logic [ByteW-1:0] store_index;
    logic [ByteW-1:0] store_byte;
    logic             frame_done;
    logic [ByteW-1:0] frame_length;
    logic [1:0]       end_cause;
  } hlps_out_t;

  // Saturating add of two timer values
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TimeW] ? TimeMax : sum[TimeW-1:0];
  endfunction

endpackage

// ===== rtl/core/hlps_cfg.sv =====
// Configuration register bank of the poll link sequencer.
`timescale 1ns / 1ps

module hlps_cfg
  import hlps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SEND_INTERVAL:   cfg_d.send_interval   = cfg_data_i;
        REG_TURNAROUND_WAIT: cfg_d.turnaround_wait = cfg_data_i;
        REG_BYTE_GAP_LIMIT:  cfg_d.byte_gap_limit  = cfg_data_i;
        REG_NO_ANSWER_LIMIT: cfg_d.no_answer_limit = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.send_interval   <= SendIntervalRst;
      cfg_q.turnaround_wait <= TurnaroundWaitRst;
      cfg_q.byte_gap_limit  <= ByteGapLimitRst;
      cfg_q.no_answer_limit <= NoAnswerLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/hlps_step.sv =====
// Next-state and result logic for one scheduler tick.
`timescale 1ns / 1ps

module hlps_step
  import hlps_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 255
) (
  input  cfg_t        cfg_i,
  input  link_state_t state_i,
  input  hlps_in_t    tick_i,
  output link_state_t state_o,
  output hlps_out_t   result_o
);

  localparam logic [ByteW-1:0] MaxFrameW = ByteW'(MAX_FRAME);

  phase_e           next_phase;
  logic [TimeW-1:0] idle_base;
  logic [ByteW-1:0] cnt_v;
  logic             gap, noans, full;

  always_comb begin
    next_phase = state_i.phase;
    state_o    = state_i;
    result_o   = '0;
    idle_base  = state_i.idle_timer;
    cnt_v      = state_i.rx_count;
    gap        = 1'b0;
    noans      = 1'b0;
    full       = 1'b0;

    case (state_i.phase)
      PH_PRESEND: begin
        if (state_i.phase_timer > cfg_i.send_interval && tick_i.send_request) begin
          next_phase              = PH_WAIT;
          result_o.begin_transmit = 1'b1;
        end
      end
      PH_WAIT: begin
        if (state_i.phase_timer >= cfg_i.turnaround_wait) begin
          next_phase          = PH_SEND;
          result_o.start_send = 1'b1;
        end
      end
      PH_SEND: begin
        if (!tick_i.tx_busy) begin
          next_phase       = PH_RECV;
          state_o.rx_count = '0;
        end
      end
      PH_RECV: begin
        // Take at most one byte, restart the gap timer on it
        if (tick_i.rx_valid && state_i.rx_count < MaxFrameW) begin
          result_o.store_valid = 1'b1;
          result_o.store_index = state_i.rx_count;
          result_o.store_byte  = tick_i.rx_byte;
          cnt_v                = state_i.rx_count + ByteW'(1);
          idle_base            = '0;
        end
        state_o.rx_count   = cnt_v;
        state_o.idle_timer = sat_add(idle_base, tick_i.elapsed);
        gap   = (cnt_v != '0) && (state_o.idle_timer >= cfg_i.byte_gap_limit);
        noans = state_o.idle_timer > cfg_i.no_answer_limit;
        full  = cnt_v >= MaxFrameW;
        if (gap || noans || full) begin
          next_phase            = PH_DONE;
          result_o.frame_done   = 1'b1;
          result_o.frame_length = cnt_v;
          result_o.end_cause    = gap   ? CAUSE_GAP :
                                  noans ? CAUSE_NOANS : CAUSE_FULL;
        end
      end
      default: begin
        next_phase         = PH_PRESEND;
        state_o.idle_timer = '0;
      end
    endcase

    state_o.phase       = next_phase;
    state_o.phase_timer = sat_add((next_phase != state_i.phase) ? '0 : state_i.phase_timer,
                                  tick_i.elapsed);
    result_o.phase      = next_phase;
  end

endmodule

// ===== rtl/core/halfduplex_poll_link_sequencer.sv =====
// Top level of the half-duplex poll link master sequencer.
`timescale 1ns / 1ps

// Master side of a half-duplex poll link. Each input word is one scheduler
// tick: elapsed time, send request, transmitter busy flag and at most one
// received byte. Each tick yields exactly one output word with the phase
// after the tick and the pulses begin_transmit, start_send, store_valid
// (with index and byte) and frame_done (with length and end cause).
//
// Channels: in_* and out_* use valid/stall; a word moves at a clock edge
// with valid high and stall low. Configuration is a plain write port
// (cfg_we_i, cfg_idx_i, cfg_data_i), to be written by the user only while
// the block is idle; the block itself does not enforce this.
//
// An accepted input word is loaded into the input register; its step
// result then moves into the output register, where it is offered.
// Throughput: one tick per cycle while out_stall_i is low; the link state
// updates as a word moves from the input register into the output register.
//
// Reset: phase goes to presend, both timers and the byte count clear, and
// the configuration takes its default values. Both stages come up empty.
// Stall: when out_stall_i holds a full output register, the input register
// holds too, and in_stall_o rises once it is occupied.
module halfduplex_poll_link_sequencer
  import hlps_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hlps_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hlps_out_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_data_i
);

  cfg_t        cfg;
  link_state_t state_q, state_d;
  hlps_out_t   result;

  logic        in_valid_q;
  hlps_in_t    in_data_q;
  logic        out_valid_q;
  hlps_out_t   out_data_q;

  logic        out_free;
  logic        advance;
  logic        in_take;

  hlps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hlps_step #(
    .MAX_FRAME (MAX_FRAME)
  ) u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .tick_i   (in_data_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Output register is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  // Input register takes a word when empty or moving on
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      state_q.phase       <= PH_PRESEND;
      state_q.phase_timer <= '0;
      state_q.idle_timer  <= '0;
      state_q.rx_count    <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on the handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/hlps_chk.sv =====
// Port-level checker for the poll link sequencer, bound to the top level.
`timescale 1ns / 1ps

module hlps_chk
  import hlps_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input hlps_out_t out_data_o
);

  // A stalled output word stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // Input backpressure only comes from a stalled full output
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // An accepted tick is followed by a valid output word
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("accepted tick not offered at output");

  // Frame fields are zero unless a frame finishes
  a_frame_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.frame_done |->
      out_data_o.frame_length == '0 && out_data_o.end_cause == '0)
    else $error("frame fields set without frame_done");

endmodule

bind halfduplex_poll_link_sequencer hlps_chk u_hlps_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
